[src/p2c_pkg.sv]
package p2c_pkg;

	// fixed-point format of coordinates and results
	localparam int FRAC_BITS = 16;
	localparam int COORD_W = 32;
	localparam int GUARD_BITS = 8;

	localparam int CORDIC_STEPS_DEF = 20;
	localparam int MAX_STEPS = 32;

	// widths of the rotation datapath
	localparam int VW = 40;
	localparam int XW = 42;
	localparam int ZW = 33;
	localparam int RES_W = COORD_W + GUARD_BITS - GUARD_BITS + 2;

	localparam logic [63:0] INV_TWO_PI_Q64 = 64'h28BE_60DB_9391_054A;
	localparam logic [63:0] INV_360_Q64 = 64'd51240955760304310;
	localparam logic [31:0] GAIN_Q32 = 32'h9B74_EDA8;

	localparam logic [63:0] CONV_RAD =
		(INV_TWO_PI_Q64 + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
	localparam logic [63:0] CONV_DEG =
		(INV_360_Q64 + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;

	// eighth turn offset and residual range in phase units
	localparam logic [31:0] EIGHTH_TURN = 32'h2000_0000;

	localparam int CFG_ADDR_W = 1;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_SWAP_ORDER,
		REG_DEGREE_MODE
	} cfg_reg_t;

	typedef enum logic [1:0] {
		QUAD_0,
		QUAD_90,
		QUAD_180,
		QUAD_270
	} quad_t;

	localparam logic [31:0] ATAN_PHASE [MAX_STEPS] = '{
		32'h2000_0000, 32'h12E4_051D, 32'h09FB_385B, 32'h0511_11D4,
		32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
		32'h0028_BE53, 32'h0014_5F2E, 32'h000A_2F98, 32'h0005_17CC,
		32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2F9, 32'h0000_517C,
		32'h0000_28BE, 32'h0000_145F, 32'h0000_0A2F, 32'h0000_0517,
		32'h0000_028B, 32'h0000_0145, 32'h0000_00A2, 32'h0000_0051,
		32'h0000_0028, 32'h0000_0014, 32'h0000_000A, 32'h0000_0005,
		32'h0000_0002, 32'h0000_0001, 32'h0000_0000, 32'h0000_0000
	};

	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
	} rot_t;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic               sat;
	} res_t;

endpackage

[src/p2c_point_if.sv]
interface p2c_point_if;
	logic                                valid;
	logic                                ready;
	logic signed [p2c_pkg::COORD_W-1:0] coord_first;
	logic signed [p2c_pkg::COORD_W-1:0] coord_second;

	modport source (output valid, output coord_first, output coord_second, input ready);
	modport sink (input valid, input coord_first, input coord_second, output ready);
endinterface

[src/p2c_result_if.sv]
interface p2c_result_if;
	logic                                valid;
	logic                                ready;
	logic signed [p2c_pkg::COORD_W-1:0] x_out;
	logic signed [p2c_pkg::COORD_W-1:0] y_out;
	logic                                saturated;

	modport source (output valid, output x_out, output y_out, output saturated, input ready);
	modport sink (input valid, input x_out, input y_out, input saturated, output ready);
endinterface

[src/p2c_cfg_if.sv]
interface p2c_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [p2c_pkg::CFG_ADDR_W-1:0]   addr;
	logic [p2c_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, output addr, output data, input ready);
	modport sink (input valid, input addr, input data, output ready);
endinterface

[src/p2c_cordic_stage.sv]
module p2c_cordic_stage #(
	parameter int STEP = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          vld_in,
	input  p2c_pkg::rot_t rot_in,
	output logic          vld_out,
	output p2c_pkg::rot_t rot_out
);

	logic signed [p2c_pkg::XW-1:0] dx;
	logic signed [p2c_pkg::XW-1:0] dy;
	logic signed [p2c_pkg::ZW-1:0] da;
	p2c_pkg::rot_t                 rot_nxt;

	always_comb begin
		dx = $signed(rot_in.y) >>> STEP;
		dy = $signed(rot_in.x) >>> STEP;
		da = $signed({{(p2c_pkg::ZW-32){1'b0}}, p2c_pkg::ATAN_PHASE[STEP]});
		if (!rot_in.z[p2c_pkg::ZW-1]) begin
			rot_nxt.x = $signed(rot_in.x) - dx;
			rot_nxt.y = $signed(rot_in.y) + dy;
			rot_nxt.z = $signed(rot_in.z) - da;
		end else begin
			rot_nxt.x = $signed(rot_in.x) + dx;
			rot_nxt.y = $signed(rot_in.y) - dy;
			rot_nxt.z = $signed(rot_in.z) + da;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else if (en) begin
			vld_out <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rot_out <= rot_nxt;
		end
	end

endmodule

[src/p2c_out_buf.sv]
module p2c_out_buf (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 up_valid,
	input  p2c_pkg::res_t        up_data,
	output logic                 up_ready,
	p2c_result_if.source         result
);

	logic          out_valid_q;
	logic          skid_valid_q;
	p2c_pkg::res_t out_q;
	p2c_pkg::res_t skid_q;
	logic          push;
	logic          out_load;

	assign up_ready = !skid_valid_q;
	assign push     = up_valid && up_ready;
	assign out_load = !out_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q  <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= skid_valid_q ? skid_q : up_data;
		end else if (push) begin
			skid_q <= up_data;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.x_out     = $signed(out_q.x);
	assign result.y_out     = $signed(out_q.y);
	assign result.saturated = out_q.sat;

endmodule

[src/polar_to_cartesian.sv]
// pipeline from an accepted point to its result word: phase multiply,
// phase add, quadrant fold, one stage per micro-rotation, rounding,
// output register
// throughput: one point per cycle unless the result side stalls; a two-word output buffer absorbs stalls
// reset: arst_n clears all valid bits and both settings to zero
module polar_to_cartesian #(
	parameter int CORDIC_STEPS = p2c_pkg::CORDIC_STEPS_DEF
) (
	input logic          clk,
	input logic          arst_n,
	p2c_point_if.sink    point,
	p2c_result_if.source result,
	p2c_cfg_if.sink      cfg
);

	localparam int NS = CORDIC_STEPS + 4;
	localparam int VLO = 32 - p2c_pkg::GUARD_BITS;
	localparam int XW = p2c_pkg::XW;
	localparam int VW = p2c_pkg::VW;
	localparam int ZW = p2c_pkg::ZW;
	localparam int CW = p2c_pkg::COORD_W;

	logic swap_order_q;
	logic degree_mode_q;

	logic [NS-1:0]           en;
	logic [NS-1:0]           vld;
	logic                    vld_s1;
	logic                    vld_s2;
	logic                    vld_s3;
	logic [CORDIC_STEPS-1:0] vld_rot;
	logic                    vld_res_s;
	logic                    buf_ready;

	assign vld = {vld_res_s, vld_rot, vld_s3, vld_s2, vld_s1};

	// settings
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			swap_order_q  <= 1'b0;
			degree_mode_q <= 1'b0;
		end else if (cfg.valid) begin
			case (p2c_pkg::cfg_reg_t'(cfg.addr))
				p2c_pkg::REG_SWAP_ORDER: begin
					swap_order_q <= cfg.data[0];
				end
				p2c_pkg::REG_DEGREE_MODE: begin
					degree_mode_q <= cfg.data[0];
				end
				default: begin
				end
			endcase
		end
	end

	// stage enables: a stage moves when it is empty or the next one moves
	assign en[NS-1] = !vld[NS-1] || buf_ready;
	for (genvar k = 0; k < NS - 1; k++) begin : g_en
		assign en[k] = !vld[k] || en[k+1];
	end

	assign point.ready = en[0];

	// stage 1: radius gain and angle-to-phase products
	logic signed [CW-1:0] rad;
	logic signed [CW-1:0] ang;
	logic [63:0]          conv;
	logic signed [64:0]   plo_full;
	logic [31:0]          phi_full;
	logic signed [64:0]   rk_full;
	logic [63:0]          plo_s1;
	logic [31:0]          phi_s1;
	logic signed [VW-1:0] v_s1;

	always_comb begin
		rad      = swap_order_q ? point.coord_second : point.coord_first;
		ang      = swap_order_q ? point.coord_first : point.coord_second;
		conv     = degree_mode_q ? p2c_pkg::CONV_DEG : p2c_pkg::CONV_RAD;
		plo_full = $signed(ang) * $signed({1'b0, conv[31:0]});
		phi_full = ang * conv[63:32];
		rk_full  = $signed(rad) * $signed({1'b0, p2c_pkg::GAIN_Q32});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en[0]) begin
			vld_s1 <= point.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			plo_s1 <= plo_full[63:0];
			phi_s1 <= phi_full;
			v_s1   <= rk_full[VLO+VW-1:VLO];
		end
	end

	// stage 2: rounded upper word of the phase product
	logic [31:0]          phase_s2;
	logic signed [VW-1:0] v_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en[1]) begin
			vld_s2 <= vld[0];
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			phase_s2 <= plo_s1[63:32] + phi_s1 + {31'd0, plo_s1[31]};
			v_s2     <= v_s1;
		end
	end

	// stage 3: quadrant fold and start vector
	logic [31:0]          pq;
	p2c_pkg::quad_t       quad;
	logic signed [XW-1:0] vx;
	p2c_pkg::rot_t        rot_init;
	p2c_pkg::rot_t        rot_s3;
	p2c_pkg::rot_t        rot_s [CORDIC_STEPS+1];

	always_comb begin
		pq         = phase_s2 + p2c_pkg::EIGHTH_TURN;
		quad       = p2c_pkg::quad_t'(pq[31:30]);
		vx         = {{(XW-VW){v_s2[VW-1]}}, v_s2};
		rot_init.z = $signed({{(ZW-30){1'b0}}, pq[29:0]})
			- $signed({{(ZW-32){1'b0}}, p2c_pkg::EIGHTH_TURN});
		case (quad)
			p2c_pkg::QUAD_0: begin
				rot_init.x = vx;
				rot_init.y = '0;
			end
			p2c_pkg::QUAD_90: begin
				rot_init.x = '0;
				rot_init.y = vx;
			end
			p2c_pkg::QUAD_180: begin
				rot_init.x = -vx;
				rot_init.y = '0;
			end
			p2c_pkg::QUAD_270: begin
				rot_init.x = '0;
				rot_init.y = -vx;
			end
			default: begin
				rot_init.x = '0;
				rot_init.y = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en[2]) begin
			vld_s3 <= vld[1];
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			rot_s3 <= rot_init;
		end
	end

	assign rot_s[0] = rot_s3;

	// micro-rotations, one per stage
	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
		p2c_cordic_stage #(
			.STEP(i)
		) u_stage (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en[3+i]),
			.vld_in (vld[2+i]),
			.rot_in (rot_s[i]),
			.vld_out(vld_rot[i]),
			.rot_out(rot_s[i+1])
		);
	end

	// last stage: drop guard bits with rounding, then clamp
	localparam int RW = XW - p2c_pkg::GUARD_BITS;

	logic signed [XW-1:0] xr_full;
	logic signed [XW-1:0] yr_full;
	logic signed [RW-1:0] xr;
	logic signed [RW-1:0] yr;
	logic                 x_clip;
	logic                 y_clip;
	p2c_pkg::res_t        res_nxt;
	p2c_pkg::res_t        res_s;

	always_comb begin
		xr_full = $signed(rot_s[CORDIC_STEPS].x)
			+ $signed(XW'(1) <<< (p2c_pkg::GUARD_BITS - 1));
		yr_full = $signed(rot_s[CORDIC_STEPS].y)
			+ $signed(XW'(1) <<< (p2c_pkg::GUARD_BITS - 1));
		xr      = xr_full[XW-1:p2c_pkg::GUARD_BITS];
		yr      = yr_full[XW-1:p2c_pkg::GUARD_BITS];
		// clipped unless all bits above the result word match its sign
		x_clip  = (xr[RW-1:CW-1] != '0) && (xr[RW-1:CW-1] != '1);
		y_clip  = (yr[RW-1:CW-1] != '0) && (yr[RW-1:CW-1] != '1);
		if (x_clip) begin
			res_nxt.x = xr[RW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
		end else begin
			res_nxt.x = xr[CW-1:0];
		end
		if (y_clip) begin
			res_nxt.y = yr[RW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
		end else begin
			res_nxt.y = yr[CW-1:0];
		end
		res_nxt.sat = x_clip || y_clip;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_res_s <= 1'b0;
		end else if (en[NS-1]) begin
			vld_res_s <= vld[NS-2];
		end
	end

	always_ff @(posedge clk) begin
		if (en[NS-1]) begin
			res_s <= res_nxt;
		end
	end

	p2c_out_buf u_out_buf (
		.clk     (clk),
		.arst_n  (arst_n),
		.up_valid(vld[NS-1]),
		.up_data (res_s),
		.up_ready(buf_ready),
		.result  (result)
	);

endmodule
